>>> src/first_fit_block_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("allocator check failed");

`else

`define FFBA_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define FFBA_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

>>> src/ffba_pkg.sv
package ffba_pkg;

    // Descriptor table geometry.
    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    // Datapath widths.
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 2 * ADDR_W;
    localparam int OUT_DATA_W = ((ADDR_W + STATUS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - ADDR_W - STATUS_W;

    // Register reset values.
    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'h0020_0000;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'h0100_0000;

    // Table limit as a count value, and the count step.
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] COUNT_ONE  = CNT_W'(1);

    // Configuration register indexes.
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    // Request kinds.
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 3'd0,
        STATUS_NO_MEMORY  = 3'd1,
        STATUS_TABLE_FULL = 3'd2,
        STATUS_NOT_FOUND  = 3'd3,
        STATUS_ZERO_SIZE  = 3'd4
    } status_t;

endpackage

>>> src/first_fit_block_allocator_core.sv
// Channel   | Direction | Beat contents
// s_axis    | in        | tuser: action; tdata: request_size, block_address
// m_axis    | out       | tdata: granted_address, status, zero pad
// cfg       | in        | cfg_index selects heap_base or heap_limit, no read-back
//
// One request is in work at a time; s_axis_tready is high only while idle.
// An allocate compares one descriptor per cycle through the shared adder, then appends
// the slack entry or bumps if needed, then passes on the result; a release only scans.
// The result register lets the next request enter while a result waits on m_axis_tready.
// Reset clears the descriptor count and loads the bump pointer with the heap base.
`include "first_fit_block_allocator_core_defines.svh"

module first_fit_block_allocator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request channel.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ffba_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // request_size, block_address
    input  logic                                 s_axis_tuser,  // action
    // Result channel.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ffba_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // granted_address, status, pad
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]          cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPLIT,
        ST_BUMP,
        ST_RESP
    } state_t;

    // Sequencer and request registers.
    state_t                           state_reg, state_next;
    logic                             action_reg, action_next;
    logic [ffba_pkg::ADDR_W-1:0]      size_reg, size_next;
    logic [ffba_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [ffba_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [ffba_pkg::ADDR_W-1:0]      slack_reg, slack_next;

    // Allocator state and configuration.
    logic [ffba_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [ffba_pkg::ADDR_W-1:0]      bump_reg, bump_next;
    logic [ffba_pkg::ADDR_W-1:0]      base_reg, base_next;
    logic [ffba_pkg::ADDR_W-1:0]      limit_reg, limit_next;

    // Pending result and output register.
    logic [ffba_pkg::ADDR_W-1:0]      res_addr_reg, res_addr_next;
    ffba_pkg::status_t                res_status_reg, res_status_next;
    logic                             out_valid_reg, out_valid_next;
    logic [ffba_pkg::ADDR_W-1:0]      out_addr_reg, out_addr_next;
    ffba_pkg::status_t                out_status_reg, out_status_next;

    // Descriptor memories with registered read data.
    logic [ffba_pkg::ADDR_W-1:0]      start_mem [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::ADDR_W-1:0]      len_mem   [ffba_pkg::MAX_BLOCKS];
    logic                             free_mem  [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::ADDR_W-1:0]      start_rd_reg;
    logic [ffba_pkg::ADDR_W-1:0]      len_rd_reg;
    logic                             free_rd_reg;
    logic [ffba_pkg::IDX_W-1:0]       rd_addr;

    logic                             start_we, len_we, free_we;
    logic [ffba_pkg::IDX_W-1:0]       start_wa, len_wa, free_wa;
    logic [ffba_pkg::ADDR_W-1:0]      start_wd, len_wd;
    logic                             free_wd;

    // Shared add/subtract unit.
    logic [ffba_pkg::ADDR_W-1:0]      alu_a, alu_b;
    logic                             alu_sub;
    logic [ffba_pkg::ADDR_W:0]        alu_res;

    logic                             in_accept;
    logic                             scan_end;
    logic                             table_full;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{ffba_pkg::OUT_PAD_W{1'b0}}, out_status_reg, out_addr_reg};
    assign scan_end      = (idx_reg == count_reg);
    assign table_full    = (count_reg == ffba_pkg::COUNT_FULL);
    assign rd_addr       = idx_next[ffba_pkg::IDX_W-1:0];

    // The adder: subtract for the fit and address compares, add for new addresses.
    always_comb
    begin
        alu_a   = len_rd_reg;
        alu_b   = size_reg;
        alu_sub = 1'b1;
        case (state_reg)
            ST_SCAN:
            begin
                if (action_reg == ffba_pkg::ACT_RELEASE)
                begin
                    alu_a = start_rd_reg;
                    alu_b = addr_reg;
                end
            end
            ST_SPLIT:
            begin
                alu_a   = res_addr_reg;
                alu_sub = 1'b0;
            end
            ST_BUMP:
            begin
                alu_a   = bump_reg;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_sub = 1'b1;
            end
        endcase
        alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                          : ({1'b0, alu_a} + {1'b0, alu_b});
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        slack_next      = slack_reg;
        count_next      = count_reg;
        bump_next       = bump_reg;
        base_next       = base_reg;
        limit_next      = limit_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        start_we = 1'b0;
        start_wa = count_reg[ffba_pkg::IDX_W-1:0];
        start_wd = alu_res[ffba_pkg::ADDR_W-1:0];
        len_we   = 1'b0;
        len_wa   = count_reg[ffba_pkg::IDX_W-1:0];
        len_wd   = size_reg;
        free_we  = 1'b0;
        free_wa  = idx_reg[ffba_pkg::IDX_W-1:0];
        free_wd  = 1'b0;

        // The output register drains independently of the sequencer.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    action_next = s_axis_tuser;
                    size_next   = s_axis_tdata[ffba_pkg::ADDR_W-1:0];
                    addr_next   = s_axis_tdata[ffba_pkg::IN_DATA_W-1:ffba_pkg::ADDR_W];
                    idx_next    = '0;
                    state_next  = ST_SCAN;
                end
            end

            // One descriptor per cycle; the read for the following one is already issued.
            ST_SCAN:
            begin
                res_addr_next   = '0;
                res_status_next = ffba_pkg::STATUS_OK;
                if (action_reg == ffba_pkg::ACT_ALLOC && size_reg == '0)
                begin
                    res_status_next = ffba_pkg::STATUS_ZERO_SIZE;
                    state_next      = ST_RESP;
                end
                else if (scan_end)
                begin
                    if (action_reg == ffba_pkg::ACT_RELEASE)
                    begin
                        res_status_next = ffba_pkg::STATUS_NOT_FOUND;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_BUMP;
                    end
                end
                else if (action_reg == ffba_pkg::ACT_RELEASE)
                begin
                    if (alu_res[ffba_pkg::ADDR_W-1:0] == '0)
                    begin
                        free_we    = 1'b1;
                        free_wd    = 1'b1;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        idx_next = idx_reg + ffba_pkg::COUNT_ONE;
                    end
                end
                else if (free_rd_reg && !alu_res[ffba_pkg::ADDR_W])
                begin
                    if (alu_res[ffba_pkg::ADDR_W-1:0] == '0)
                    begin
                        // Exact fit: just take the entry.
                        free_we       = 1'b1;
                        res_addr_next = start_rd_reg;
                        state_next    = ST_RESP;
                    end
                    else if (table_full)
                    begin
                        res_status_next = ffba_pkg::STATUS_TABLE_FULL;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        // Larger fit: shrink this entry, the slack is appended next.
                        free_we       = 1'b1;
                        len_we        = 1'b1;
                        len_wa        = idx_reg[ffba_pkg::IDX_W-1:0];
                        slack_next    = alu_res[ffba_pkg::ADDR_W-1:0];
                        res_addr_next = start_rd_reg;
                        state_next    = ST_SPLIT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + ffba_pkg::COUNT_ONE;
                end
            end

            // Append the free slack entry behind the granted block.
            ST_SPLIT:
            begin
                start_we   = 1'b1;
                len_we     = 1'b1;
                len_wd     = slack_reg;
                free_we    = 1'b1;
                free_wa    = count_reg[ffba_pkg::IDX_W-1:0];
                free_wd    = 1'b1;
                count_next = count_reg + ffba_pkg::COUNT_ONE;
                state_next = ST_RESP;
            end

            // Nothing fit: take space at the bump pointer if the limit allows and the table has room.
            ST_BUMP:
            begin
                if (alu_res > {1'b0, limit_reg})
                begin
                    res_status_next = ffba_pkg::STATUS_NO_MEMORY;
                end
                else if (table_full)
                begin
                    res_status_next = ffba_pkg::STATUS_TABLE_FULL;
                end
                else
                begin
                    start_we      = 1'b1;
                    start_wd      = bump_reg;
                    len_we        = 1'b1;
                    free_we       = 1'b1;
                    free_wa       = count_reg[ffba_pkg::IDX_W-1:0];
                    count_next    = count_reg + ffba_pkg::COUNT_ONE;
                    bump_next     = alu_res[ffba_pkg::ADDR_W-1:0];
                    res_addr_next = bump_reg;
                end
                state_next = ST_RESP;
            end

            // Hand the result to the output register once it is free.
            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must write the configuration only while idle; the block itself does not enforce it.
        if (cfg_we)
        begin
            if (cfg_index == ffba_pkg::REG_HEAP_BASE)
            begin
                base_next = cfg_data;
                bump_next = cfg_data;
            end
            else
            begin
                limit_next = cfg_data;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            bump_reg       <= ffba_pkg::HEAP_BASE_RESET;
            base_reg       <= ffba_pkg::HEAP_BASE_RESET;
            limit_reg      <= ffba_pkg::HEAP_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            bump_reg       <= bump_next;
            base_reg       <= base_next;
            limit_reg      <= limit_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        slack_reg      <= slack_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // Descriptor memories: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem[start_wa] <= start_wd;
        end
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        if (free_we)
        begin
            free_mem[free_wa] <= free_wd;
        end
        start_rd_reg <= start_mem[rd_addr];
        len_rd_reg   <= len_mem[rd_addr];
        free_rd_reg  <= free_mem[rd_addr];
    end

    // The table never grows past its capacity.
    `FFBA_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= ffba_pkg::COUNT_FULL)

    // The scan never runs past the last valid descriptor.
    `FFBA_ASSERT_SAME(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, idx_reg <= count_reg)

    // A failed or release result never carries an address.
    `FFBA_ASSERT_SAME(a_fail_addr_zero, clk, rst_n,
        out_valid_reg && out_status_reg != ffba_pkg::STATUS_OK, out_addr_reg == '0)

    // An accepted request starts the scan at the first descriptor.
    `FFBA_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_accept,
        state_reg == ST_SCAN && idx_reg == '0)

endmodule
